FILE: rtl/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_FINAL
  } stbs_state_e;

  typedef struct packed {
    logic write;
    logic start;
    logic step;
    logic finish;
  } stbs_cmd_t;

  typedef struct packed {
    logic narrow;
  } stbs_sts_t;

endpackage

`default_nettype wire

FILE: rtl/stbs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stbs_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic        [stbs_pkg::INDEX_W-1:0]    entry_index;
  logic signed [stbs_pkg::DATA_W-1:0]     entry_value;
  logic signed [stbs_pkg::DATA_W-1:0]     search_key;

  modport source (
    output valid, opcode, entry_index, entry_value, search_key,
    input  ready
  );

  modport sink (
    input  valid, opcode, entry_index, entry_value, search_key,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/stbs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stbs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [stbs_pkg::INDEX_W-1:0]   match_index;

  modport source (
    output valid, found, match_index,
    input  ready
  );

  modport sink (
    input  valid, found, match_index,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/stbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/stbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  input  wire logic                req_opcode_i,
  output logic                     req_ready_o,
  output logic                     rsp_valid_o,
  input  wire logic                rsp_ready_i,
  output stbs_pkg::stbs_cmd_t      cmd_o,
  input  wire stbs_pkg::stbs_sts_t sts_i
);
  import stbs_pkg::*;

  stbs_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && (req_opcode_i == OP_SEARCH)) begin
          state_d = sts_i.narrow ? ST_PROBE : ST_FINAL;
        end
      end
      ST_PROBE: begin
        state_d = sts_i.narrow ? ST_PROBE : ST_FINAL;
      end
      ST_FINAL: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.write = (req_opcode_i == OP_WRITE);
          cmd_o.start = (req_opcode_i == OP_SEARCH);
        end
      end
      ST_PROBE: begin
        cmd_o.step = 1'b1;
      end
      ST_FINAL: begin
        cmd_o.finish = !rsp_valid_q || rsp_ready_i;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!rsp_valid_q || rsp_ready_i))
    else $error("A pending result was overwritten.");

  a_rsp_from_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_FINAL))
    else $error("A result appeared without a final comparison.");

  a_probe_ends_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && !sts_i.narrow) |=> (state_q == ST_FINAL))
    else $error("The probe loop did not end in the final comparison.");

  a_write_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.write || cmd_o.start) |-> (state_q == ST_IDLE && req_ready_o))
    else $error("A transaction was taken outside the idle state.");

endmodule

`default_nettype wire

FILE: rtl/stbs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [stbs_pkg::COUNT_W-1:0] cfg_data_i,
  input  wire logic        [stbs_pkg::INDEX_W-1:0] entry_index_i,
  input  wire logic signed [stbs_pkg::DATA_W-1:0]  entry_value_i,
  input  wire logic signed [stbs_pkg::DATA_W-1:0]  search_key_i,
  input  wire stbs_pkg::stbs_cmd_t                 cmd_i,
  output stbs_pkg::stbs_sts_t                      sts_o,
  output logic                                     found_o,
  output logic             [stbs_pkg::INDEX_W-1:0] match_index_o
);
  import stbs_pkg::*;

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  logic        [COUNT_W-1:0] count_q;
  logic signed [DATA_W-1:0]  key_q;
  logic                      empty_q;
  logic        [AW-1:0]      low_q, low_d;
  logic        [AW-1:0]      high_q, high_d;
  logic        [AW-1:0]      mid_q, addr;
  logic        [AW:0]        sum;
  logic        [31:0]        count32, n32, nm1, idx32, low32;
  logic signed [DATA_W-1:0]  rdata;
  logic                      we;
  logic                      hit;
  logic                      found_q;
  logic        [INDEX_W-1:0] match_q;

  assign count32 = 32'(count_q);
  assign n32     = (count32 > DEPTH32) ? DEPTH32 : count32;
  assign nm1     = (count_q == '0) ? 32'd0 : (n32 - 32'd1);
  assign idx32   = 32'(entry_index_i);
  assign we      = cmd_i.write && (idx32 < DEPTH32);

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    if (cmd_i.start) begin
      low_d  = '0;
      high_d = nm1[AW-1:0];
    end else if (cmd_i.step) begin
      if (key_q <= rdata) begin
        high_d = mid_q;
      end else begin
        low_d = mid_q + AW'(1);
      end
    end
  end

  assign sum         = {1'b0, low_d} + {1'b0, high_d};
  assign sts_o.narrow = (low_d < high_d);
  assign addr        = sts_o.narrow ? sum[AW:1] : low_d;

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx32[AW-1:0]),
    .wdata_i (entry_value_i),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign low32 = 32'(low_q);
  assign hit   = !empty_q && (rdata == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    mid_q  <= addr;
    if (cmd_i.start) begin
      key_q   <= search_key_i;
      empty_q <= (count_q == '0);
    end
    if (cmd_i.finish) begin
      found_q <= hit;
      match_q <= hit ? low32[INDEX_W-1:0] : '0;
    end
  end

  assign found_o       = found_q;
  assign match_index_o = match_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_table_binary_search.sv
// Sorted table search: write transactions (opcode 0) load one signed 32-bit entry of a
// TABLE_DEPTH-entry table held in a single RAM, and search transactions (opcode 1) run a
// lower-bound binary search over the first entry_count entries, returning whether the key
// is present and the lowest index holding it. A write gives no result. A search makes k
// halving probes, k between floor(log2(n)) and ceil(log2(n)) for n = min(entry_count,
// TABLE_DEPTH) entries, each waiting on one registered RAM read, and then a final
// comparison. One transaction is worked on at a time; the result register lets the next
// transaction be taken while a result still waits. entry_count must only be written while
// the block is idle, and only written entries may be searched.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [stbs_pkg::COUNT_W-1:0] cfg_data_i,
  stbs_req_if.sink                          req_i,
  stbs_rsp_if.source                        rsp_o
);
  import stbs_pkg::*;

  stbs_cmd_t cmd;
  stbs_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (req_i.entry_index),
    .entry_value_i (req_i.entry_value),
    .search_key_i  (req_i.search_key),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .found_o       (rsp_o.found),
    .match_index_o (rsp_o.match_index)
  );

endmodule

`default_nettype wire
